@@ sv/ect_pkg.sv @@
package ect_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int WAITER_W = 8;
  localparam int STATUS_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_CREATE  = 2'd0;
  localparam cmd_t CMD_DESTROY = 2'd1;
  localparam cmd_t CMD_WAIT    = 2'd2;
  localparam cmd_t CMD_SIGNAL  = 2'd3;

  localparam status_t STAT_OK      = 3'd0;
  localparam status_t STAT_INVALID = 3'd1;
  localparam status_t STAT_BUSY    = 3'd2;
  localparam status_t STAT_FULL    = 3'd3;
  localparam status_t STAT_BLOCKED = 3'd4;

endpackage

@@ sv/event_counter_table.sv @@
// event_counter_table: a table of semaphore-style event counters, each with
// one waiter slot.
// Input channel: an item (in_cmd, in_counter_id, in_waiter_id) is taken at a
// rising edge with start high and busy low. Commands are create, destroy,
// wait and signal.
// Result channel: exactly one result per item, shown for one cycle with
// out_valid high: out_status, out_new_id, out_woken_valid, out_woken_waiter.
// The receiver cannot stall; every result must be taken when shown.
// Timing: the item's slot is read from the count and waiter memories into
// registers at the accept edge; the block then spends its execute state (busy
// high), at whose end the read-modify-write completes and the result register
// loads, raising out_valid. No new item is taken while busy, so each item
// finishes its write back before the next one is read.
// Create picks the lowest free slot with a priority encoder over the in-use
// flags in the same cycle as the write back.
// Reset (rst_n low, synchronous) frees every slot and drops every waiter;
// the memories need no clearing since create writes a zero count.
module event_counter_table
  import ect_pkg::*;
#(
  parameter int NUM_COUNTERS = 16,
  parameter int COUNT_BITS   = 16,
  parameter int WAITER_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cmd_t                in_cmd,
  input  logic [ID_W-1:0]     in_counter_id,
  input  logic [WAITER_W-1:0] in_waiter_id,
  output logic                out_valid,
  output status_t             out_status,
  output logic [ID_W-1:0]     out_new_id,
  output logic                out_woken_valid,
  output logic [WAITER_W-1:0] out_woken_waiter
);

  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [NUM_COUNTERS-1:0] in_use_r, in_use_nxt;
  logic [NUM_COUNTERS-1:0] present_r, present_nxt;

  logic [COUNT_BITS-1:0]  count_mem [NUM_COUNTERS];
  logic [WAITER_BITS-1:0] wid_mem   [NUM_COUNTERS];
  logic [COUNT_BITS-1:0]  count_q;
  logic [WAITER_BITS-1:0] wid_q;

  cmd_t                   cmd_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   in_range_r;
  logic [WAITER_BITS-1:0] caller_r;

  logic                   accept;
  logic                   in_range;
  logic [IDX_W-1:0]       rd_idx;

  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_wa;
  logic [COUNT_BITS-1:0]  cnt_wd;
  logic                   wid_we;

  logic                   live;
  logic [COUNT_BITS-1:0]  count_inc;
  status_t                status_nxt;
  logic [ID_W-1:0]        new_id_nxt;
  logic                   woke_nxt;
  logic [WAITER_W-1:0]    who_nxt;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [ID_W-1:0]        out_new_id_r;
  logic                   out_woken_valid_r;
  logic [WAITER_W-1:0]    out_woken_waiter_r;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  // ids at or above the table size are invalid
  assign in_range = (32'(in_counter_id) < NUM_COUNTERS);
  assign rd_idx   = IDX_W'(in_counter_id);

  ect_find_free #(
    .N  (NUM_COUNTERS),
    .IW (IDX_W)
  ) u_find_free (
    .used  (in_use_r),
    .found (free_found),
    .idx   (free_idx)
  );

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    if (wid_we) begin
      wid_mem[idx_r] <= caller_r;
    end
    if (accept) begin
      count_q <= count_mem[rd_idx];
      wid_q   <= wid_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      idx_r      <= rd_idx;
      in_range_r <= in_range;
      caller_r   <= WAITER_BITS'(in_waiter_id);
    end
  end

  assign live      = in_range_r && in_use_r[idx_r];
  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_BITS'(1);

  always_comb begin
    state_nxt   = state_r;
    in_use_nxt  = in_use_r;
    present_nxt = present_r;
    cnt_we      = 1'b0;
    cnt_wa      = idx_r;
    cnt_wd      = '0;
    wid_we      = 1'b0;
    status_nxt  = STAT_OK;
    new_id_nxt  = '0;
    woke_nxt    = 1'b0;
    who_nxt     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (cmd_r == CMD_CREATE) begin
          if (free_found) begin
            in_use_nxt[free_idx]  = 1'b1;
            present_nxt[free_idx] = 1'b0;
            cnt_we     = 1'b1;
            cnt_wa     = free_idx;
            new_id_nxt = ID_W'(free_idx);
          end else begin
            status_nxt = STAT_FULL;
          end
        end else if (!live) begin
          status_nxt = STAT_INVALID;
        end else begin
          case (cmd_r)
            CMD_DESTROY: begin
              // the waiter is woken as by a signal, but the count is written to zero, not incremented
              woke_nxt = present_r[idx_r];
              who_nxt  = woke_nxt ? WAITER_W'(wid_q) : '0;
              in_use_nxt[idx_r]  = 1'b0;
              present_nxt[idx_r] = 1'b0;
              cnt_we = 1'b1;
            end
            CMD_WAIT: begin
              if (count_q != '0) begin
                cnt_we = 1'b1;
                cnt_wd = count_q - COUNT_BITS'(1);
              end else if (!present_r[idx_r]) begin
                present_nxt[idx_r] = 1'b1;
                wid_we     = 1'b1;
                status_nxt = STAT_BLOCKED;
              end else begin
                status_nxt = STAT_BUSY;
              end
            end
            default: begin
              woke_nxt = present_r[idx_r];
              who_nxt  = woke_nxt ? WAITER_W'(wid_q) : '0;
              present_nxt[idx_r] = 1'b0;
              cnt_we = 1'b1;
              cnt_wd = count_inc;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      present_r   <= present_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_status_r       <= status_nxt;
      out_new_id_r       <= new_id_nxt;
      out_woken_valid_r  <= woke_nxt;
      out_woken_waiter_r <= who_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_new_id       = out_new_id_r;
  assign out_woken_valid  = out_woken_valid_r;
  assign out_woken_waiter = out_woken_waiter_r;

`ifndef SYNTH
  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC))
    else $error("result without an item in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("item did not finish in one execute cycle");

  a_woken_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_woken_valid |-> out_status == STAT_OK)
    else $error("waiter released on a failed item");

  a_new_id_only_on_create: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_id != '0) |-> out_status == STAT_OK && !out_woken_valid)
    else $error("new id on a result other than a successful create");
`endif

endmodule

@@ sv/ect_find_free.sv @@
module ect_find_free #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  used,
  output logic          found,
  output logic [IW-1:0] idx
);

  // lowest clear bit wins, so scan from the top down
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign found = ~&used;

endmodule
